FILE: src/bas_pkg.sv
`default_nettype none

package bas_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int TIME_BITS = WORD_BITS - 1;
  localparam int VEL_BITS  = 52;

  typedef logic signed [WORD_BITS-1:0] sword_t;
  typedef logic [TIME_BITS-1:0]        time_t;

  localparam sword_t WORD_MAX      = 32'sh7FFF_FFFF;
  localparam sword_t WORD_MIN      = 32'sh8000_0000;
  localparam sword_t GRAV_Z_RESET  = -32'sd106168;

  typedef enum logic [2:0] {
    CFG_GRAVITY_X    = 3'd0,
    CFG_GRAVITY_Y    = 3'd1,
    CFG_GRAVITY_Z    = 3'd2,
    CFG_BOX_CENTER_X = 3'd3,
    CFG_BOX_CENTER_Y = 3'd4,
    CFG_BOX_CENTER_Z = 3'd5,
    CFG_BOX_HALF_XY  = 3'd6,
    CFG_BOX_HALF_Z   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TIME = 2'd1,
    ST_OUTSIDE  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    sword_t launch_x;
    sword_t launch_y;
    sword_t launch_z;
    sword_t aim_x;
    sword_t aim_y;
    sword_t aim_z;
    time_t  flight_time;
  } in_t;

  typedef struct packed {
    sword_t  launch_vel_x;
    sword_t  launch_vel_y;
    sword_t  launch_vel_z;
    sword_t  land_vel_x;
    sword_t  land_vel_y;
    sword_t  land_vel_z;
    time_t   apex_sec;
    status_t status;
  } out_t;

  typedef struct packed {
    sword_t [2:0]          grav;
    sword_t [2:0]          center;
    logic   [2:0][31:0]    half;
  } cfg_t;

  // one arc as it moves between the sections of the pipeline
  typedef struct packed {
    logic         tzero;
    logic         ovf;
    logic         outside;
    time_t        flight;
    sword_t [2:0] launch;
    sword_t [2:0] vo;
    sword_t [2:0] ld;
    time_t        apex;
  } arc_t;

  typedef struct packed {
    sword_t val;
    logic   ovf;
  } sat_t;

  function automatic logic [WORD_BITS-1:0] abs_word(input sword_t x);
    return x[WORD_BITS-1] ? WORD_BITS'(-x) : WORD_BITS'(x);
  endfunction

  function automatic sat_t sat_word(input logic signed [VEL_BITS-1:0] x);
    sat_t r;
    r.val = sword_t'(x[WORD_BITS-1:0]);
    r.ovf = 1'b0;
    if (x > VEL_BITS'(WORD_MAX)) begin
      r.val = WORD_MAX;
      r.ovf = 1'b1;
    end else if (x < VEL_BITS'(WORD_MIN)) begin
      r.val = WORD_MIN;
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  // |p - c| <= h
  function automatic logic box_ok(input logic signed [63:0] p, input sword_t c,
                                  input logic [31:0] h);
    logic signed [63:0] diff;
    logic [63:0]        m;
    diff = p - 64'(c);
    m = diff[63] ? 64'(-diff) : 64'(diff);
    return m <= 64'(h);
  endfunction

endpackage

`default_nettype wire

FILE: src/bas_velocity.sv
`default_nettype none

module bas_velocity import bas_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic up_valid,
  output logic up_ready,
  input  in_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output arc_t dn_data
);

  localparam int QUOT_BITS  = WORD_BITS + FRAC_BITS;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_STAGES = QUOT_BITS / DIV_STEPS;
  localparam int STAGES     = DIV_STAGES + 2;
  localparam int GT_BITS    = WORD_BITS + TIME_BITS;

  typedef struct packed {
    arc_t                             item;
    logic [2:0]                       dneg;
    logic [2:0][GT_BITS-1:0]          gt;
    logic [2:0][TIME_BITS-1:0]        rem;
    logic [2:0][QUOT_BITS-1:0]        nq;
  } vpipe_t;

  vpipe_t            st_r   [STAGES];
  vpipe_t            st_nxt [STAGES];
  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] vin;
  logic [STAGES:0]   rdy;

  assign vin = {valid_r[STAGES-2:0], up_valid};

  always_comb begin
    rdy[STAGES] = dn_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    logic signed [WORD_BITS:0]   d;
    logic [WORD_BITS-1:0]        dmag;
    logic [WORD_BITS-1:0]        gmag;
    logic [TIME_BITS:0]          rsh;
    logic                        qb;
    logic signed [VEL_BITS-1:0]  qs, hs, gs, v, lv;
    sat_t                        sv, sl;
    sword_t [2:0]                lp, ap;

    lp = {up_data.launch_z, up_data.launch_y, up_data.launch_x};
    ap = {up_data.aim_z, up_data.aim_y, up_data.aim_x};

    // front: differences, |g|*T, box test of launch and aim points
    st_nxt[0] = '0;
    st_nxt[0].item.tzero  = (up_data.flight_time == '0);
    st_nxt[0].item.flight = up_data.flight_time;
    st_nxt[0].item.launch = lp;
    for (int i = 0; i < 3; i++) begin
      d = {ap[i][WORD_BITS-1], ap[i]} - {lp[i][WORD_BITS-1], lp[i]};
      dmag = d[WORD_BITS] ? WORD_BITS'(-d) : d[WORD_BITS-1:0];
      gmag = abs_word(cfg.grav[i]);
      st_nxt[0].dneg[i] = d[WORD_BITS];
      st_nxt[0].gt[i]   = GT_BITS'(gmag) * GT_BITS'(up_data.flight_time);
      st_nxt[0].nq[i]   = {dmag, {FRAC_BITS{1'b0}}};
      if (!box_ok(64'(lp[i]), cfg.center[i], cfg.half[i]) ||
          !box_ok(64'(ap[i]), cfg.center[i], cfg.half[i])) begin
        st_nxt[0].item.outside = 1'b1;
      end
    end

    // restoring division d*2^F / T, DIV_STEPS quotient bits per stage
    for (int k = 1; k <= DIV_STAGES; k++) begin
      st_nxt[k] = st_r[k-1];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < DIV_STEPS; j++) begin
          rsh = {st_nxt[k].rem[i], st_nxt[k].nq[i][QUOT_BITS-1]};
          qb  = (rsh >= {1'b0, st_nxt[k].item.flight});
          if (qb) begin
            rsh = rsh - {1'b0, st_nxt[k].item.flight};
          end
          st_nxt[k].rem[i] = rsh[TIME_BITS-1:0];
          st_nxt[k].nq[i]  = {st_nxt[k].nq[i][QUOT_BITS-2:0], qb};
        end
      end
    end

    // v = d/T - g*T/2, landing = v + g*T, both saturated
    st_nxt[STAGES-1] = st_r[STAGES-2];
    for (int i = 0; i < 3; i++) begin
      qs = VEL_BITS'(st_r[STAGES-2].nq[i]);
      if (st_r[STAGES-2].dneg[i]) begin
        qs = -qs;
      end
      hs = VEL_BITS'(st_r[STAGES-2].gt[i][GT_BITS-1:FRAC_BITS+1]);
      gs = VEL_BITS'(st_r[STAGES-2].gt[i][GT_BITS-1:FRAC_BITS]);
      if (cfg.grav[i][WORD_BITS-1]) begin
        hs = -hs;
        gs = -gs;
      end
      v  = qs - hs;
      lv = v + gs;
      sv = sat_word(v);
      sl = sat_word(lv);
      st_nxt[STAGES-1].item.vo[i] = sv.val;
      st_nxt[STAGES-1].item.ld[i] = sl.val;
      st_nxt[STAGES-1].item.ovf   = st_nxt[STAGES-1].item.ovf | sv.ovf | sl.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (rdy[k] && vin[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = valid_r[STAGES-1];
  assign dn_data  = st_r[STAGES-1].item;

endmodule

`default_nettype wire

FILE: src/bas_apex_time.sv
`default_nettype none

module bas_apex_calc import bas_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic up_valid,
  output logic up_ready,
  input  arc_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output arc_t dn_data
);

  localparam int A_STEPS      = 4;
  localparam int A_DIV_STAGES = (TIME_BITS + A_STEPS - 1) / A_STEPS;
  localparam int DIV_FIRST    = 4;
  localparam int STAGES       = A_DIV_STAGES + 5;
  localparam int PROD_BITS    = 2 * WORD_BITS;

  typedef struct packed {
    arc_t                        item;
    logic [2:0][PROD_BITS-1:0]   pv;
    logic [2:0]                  pneg;
    logic [2:0][PROD_BITS-1:0]   gg;
    logic [PROD_BITS-1:0]        pos;
    logic [PROD_BITS-1:0]        neg;
    logic [PROD_BITS-1:0]        gsq;
    logic [PROD_BITS-1:0]        dif;
    logic [PROD_BITS-1:0]        rem;
    logic                        need;
    logic                        big;
    time_t                       nq;
  } apipe_t;

  apipe_t            st_r   [STAGES];
  apipe_t            st_nxt [STAGES];
  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] vin;
  logic [STAGES:0]   rdy;

  assign vin = {valid_r[STAGES-2:0], up_valid};

  always_comb begin
    rdy[STAGES] = dn_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    logic [WORD_BITS-1:0]  vm, gm;
    logic [PROD_BITS:0]    r65;
    logic                  qb;

    // products |v|*|g| and |g|^2
    st_nxt[0] = '0;
    st_nxt[0].item = up_data;
    for (int i = 0; i < 3; i++) begin
      vm = abs_word(up_data.vo[i]);
      gm = abs_word(cfg.grav[i]);
      st_nxt[0].pv[i]   = PROD_BITS'(vm) * PROD_BITS'(gm);
      st_nxt[0].gg[i]   = PROD_BITS'(gm) * PROD_BITS'(gm);
      st_nxt[0].pneg[i] = up_data.vo[i][WORD_BITS-1] ^ cfg.grav[i][WORD_BITS-1];
    end

    // split v.g into positive and negative parts, sum |g|^2
    st_nxt[1] = st_r[0];
    st_nxt[1].pos = '0;
    st_nxt[1].neg = '0;
    st_nxt[1].gsq = st_r[0].gg[0] + st_r[0].gg[1] + st_r[0].gg[2];
    for (int i = 0; i < 3; i++) begin
      if (st_r[0].pneg[i]) begin
        st_nxt[1].neg = st_nxt[1].neg + st_r[0].pv[i];
      end else begin
        st_nxt[1].pos = st_nxt[1].pos + st_r[0].pv[i];
      end
    end

    st_nxt[2] = st_r[1];
    st_nxt[2].need = (st_r[1].gsq != '0) && (st_r[1].neg > st_r[1].pos);
    st_nxt[2].dif  = st_r[1].neg - st_r[1].pos;

    // when the apex is needed, a quotient of 2^TIME_BITS or more always clamps to T
    st_nxt[3] = st_r[2];
    st_nxt[3].big = ({{(TIME_BITS-FRAC_BITS){1'b0}}, st_r[2].dif} >=
                     {st_r[2].gsq, {(TIME_BITS-FRAC_BITS){1'b0}}});
    st_nxt[3].rem = PROD_BITS'(st_r[2].dif[PROD_BITS-1:TIME_BITS-FRAC_BITS]);
    st_nxt[3].nq  = {st_r[2].dif[TIME_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};

    for (int k = DIV_FIRST; k < DIV_FIRST + A_DIV_STAGES; k++) begin
      st_nxt[k] = st_r[k-1];
      for (int j = 0; j < A_STEPS; j++) begin
        if ((k - DIV_FIRST) * A_STEPS + j < TIME_BITS) begin
          r65 = {st_nxt[k].rem, st_nxt[k].nq[TIME_BITS-1]};
          qb  = (r65 >= {1'b0, st_nxt[k].gsq});
          if (qb) begin
            r65 = r65 - {1'b0, st_nxt[k].gsq};
          end
          st_nxt[k].rem = r65[PROD_BITS-1:0];
          st_nxt[k].nq  = {st_nxt[k].nq[TIME_BITS-2:0], qb};
        end
      end
    end

    // clamp to [0, T]
    st_nxt[STAGES-1] = st_r[STAGES-2];
    if (!st_r[STAGES-2].need) begin
      st_nxt[STAGES-1].item.apex = '0;
    end else if (st_r[STAGES-2].big || st_r[STAGES-2].nq > st_r[STAGES-2].item.flight) begin
      st_nxt[STAGES-1].item.apex = st_r[STAGES-2].item.flight;
    end else begin
      st_nxt[STAGES-1].item.apex = st_r[STAGES-2].nq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (rdy[k] && vin[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = valid_r[STAGES-1];
  assign dn_data  = st_r[STAGES-1].item;

endmodule

`default_nettype wire

FILE: src/bas_apex_check.sv
`default_nettype none

module bas_apex_check import bas_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic up_valid,
  output logic up_ready,
  input  arc_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output out_t dn_data
);

  localparam int STAGES  = 4;
  localparam int MB      = WORD_BITS + TIME_BITS;
  localparam int SB      = MB - FRAC_BITS;
  localparam int LO_BITS = SB / 2;
  localparam int HI_BITS = SB - LO_BITS;
  localparam int PH_BITS = HI_BITS + TIME_BITS;
  localparam int PL_BITS = LO_BITS + TIME_BITS;
  localparam int G2_BITS = PH_BITS + LO_BITS;

  typedef struct packed {
    arc_t                    item;
    logic [2:0][MB-1:0]      vtr;
    logic [2:0][MB-1:0]      g1r;
    logic [2:0][SB-1:0]      vt;
    logic [2:0][PH_BITS-1:0] ph;
    logic [2:0][PL_BITS-1:0] pl;
    logic [2:0][63:0]        p;
    out_t                    res;
  } cpipe_t;

  cpipe_t            st_r   [STAGES];
  cpipe_t            st_nxt [STAGES];
  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] vin;
  logic [STAGES:0]   rdy;

  assign vin = {valid_r[STAGES-2:0], up_valid};

  always_comb begin
    rdy[STAGES] = dn_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    logic [SB-1:0]          g1;
    logic [G2_BITS-1:0]     g2w;
    logic signed [63:0]     tv, tg;
    logic                   outside;

    st_nxt[0] = '0;
    st_nxt[0].item = up_data;
    for (int i = 0; i < 3; i++) begin
      st_nxt[0].vtr[i] = MB'(abs_word(up_data.vo[i])) * MB'(up_data.apex);
      st_nxt[0].g1r[i] = MB'(abs_word(cfg.grav[i])) * MB'(up_data.apex);
    end

    // g*t truncated, then times t in two half-width products
    st_nxt[1] = st_r[0];
    for (int i = 0; i < 3; i++) begin
      g1 = st_r[0].g1r[i][MB-1:FRAC_BITS];
      st_nxt[1].vt[i] = st_r[0].vtr[i][MB-1:FRAC_BITS];
      st_nxt[1].ph[i] = PH_BITS'(g1[SB-1:LO_BITS]) * PH_BITS'(st_r[0].item.apex);
      st_nxt[1].pl[i] = PL_BITS'(g1[LO_BITS-1:0]) * PL_BITS'(st_r[0].item.apex);
    end

    // apex position L + v*t + g*t^2/2
    st_nxt[2] = st_r[1];
    for (int i = 0; i < 3; i++) begin
      g2w = {st_r[1].ph[i], {LO_BITS{1'b0}}} + G2_BITS'(st_r[1].pl[i]);
      tv  = 64'(st_r[1].vt[i]);
      tg  = 64'(g2w[G2_BITS-1:FRAC_BITS+1]);
      if (st_r[1].item.vo[i][WORD_BITS-1]) begin
        tv = -tv;
      end
      if (cfg.grav[i][WORD_BITS-1]) begin
        tg = -tg;
      end
      st_nxt[2].p[i] = 64'(st_r[1].item.launch[i]) + tv + tg;
    end

    st_nxt[3] = st_r[2];
    outside = st_r[2].item.outside;
    for (int i = 0; i < 3; i++) begin
      if (!box_ok(signed'(st_r[2].p[i]), cfg.center[i], cfg.half[i])) begin
        outside = 1'b1;
      end
    end
    st_nxt[3].res.launch_vel_x = st_r[2].item.vo[0];
    st_nxt[3].res.launch_vel_y = st_r[2].item.vo[1];
    st_nxt[3].res.launch_vel_z = st_r[2].item.vo[2];
    st_nxt[3].res.land_vel_x   = st_r[2].item.ld[0];
    st_nxt[3].res.land_vel_y   = st_r[2].item.ld[1];
    st_nxt[3].res.land_vel_z   = st_r[2].item.ld[2];
    st_nxt[3].res.apex_sec     = st_r[2].item.apex;
    if (st_r[2].item.tzero) begin
      st_nxt[3].res        = '0;
      st_nxt[3].res.status = ST_BAD_TIME;
    end else if (st_r[2].item.ovf) begin
      st_nxt[3].res.status = ST_OVERFLOW;
    end else if (outside) begin
      st_nxt[3].res.status = ST_OUTSIDE;
    end else begin
      st_nxt[3].res.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (rdy[k] && vin[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = valid_r[STAGES-1];
  assign dn_data  = st_r[STAGES-1].res;

endmodule

`default_nettype wire

FILE: src/ballistic_arc_solver.sv
// Ballistic arc solver: launch and landing velocity, apex time and box check.
// Input channel in_valid/in_ready/in_data carries a launch point, an aim point
// and a flight time; the result channel out_valid/out_ready/out_data carries
// both velocities, the apex time and a status code.
// Configuration (gravity, box center, box half extents) is written through
// cfg_we/cfg_index/cfg_data, one register per cycle; the user must do so
// only while no arc is in flight (the block does not enforce it). Throughput:
// one arc per cycle unless out_ready stalls. The 6-stage velocity divider
// (8 quotient bits per stage) and the 8-stage apex divider (4 quotient bits
// per stage, 64-bit divisor) form most stages. Each stage has its own valid
// bit and advances when the stage after it is free, so bubbles close up and
// a stalled receiver fills the pipeline before in_ready drops; nothing is
// lost or repeated. Reset (rst_n low, synchronous) empties the pipeline and
// loads the configuration defaults: gravity (0, 0, -1.62 m/s^2), box zero.
`default_nettype none

module ballistic_arc_solver import bas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t cfg_r;
  logic v2a_valid, v2a_ready;
  arc_t v2a_data;
  logic a2c_valid, a2c_ready;
  arc_t a2c_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{grav: {GRAV_Z_RESET, sword_t'(0), sword_t'(0)}, center: '0, half: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAVITY_X:    cfg_r.grav[0]   <= sword_t'(cfg_data[31:0]);
        CFG_GRAVITY_Y:    cfg_r.grav[1]   <= sword_t'(cfg_data[31:0]);
        CFG_GRAVITY_Z:    cfg_r.grav[2]   <= sword_t'(cfg_data[31:0]);
        CFG_BOX_CENTER_X: cfg_r.center[0] <= sword_t'(cfg_data[31:0]);
        CFG_BOX_CENTER_Y: cfg_r.center[1] <= sword_t'(cfg_data[31:0]);
        CFG_BOX_CENTER_Z: cfg_r.center[2] <= sword_t'(cfg_data[31:0]);
        CFG_BOX_HALF_XY: begin
          cfg_r.half[0] <= cfg_data[31:0];
          cfg_r.half[1] <= cfg_data[63:32];
        end
        CFG_BOX_HALF_Z:   cfg_r.half[2]   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  bas_velocity u_vel (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (v2a_valid),
    .dn_ready (v2a_ready),
    .dn_data  (v2a_data)
  );

  bas_apex_calc u_apex (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (v2a_valid),
    .up_ready (v2a_ready),
    .up_data  (v2a_data),
    .dn_valid (a2c_valid),
    .dn_ready (a2c_ready),
    .dn_data  (a2c_data)
  );

  bas_apex_check u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (a2c_valid),
    .up_ready (a2c_ready),
    .up_data  (a2c_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without an output stall");

  a_bad_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_BAD_TIME |->
      out_data.apex_sec == '0 && out_data.launch_vel_x == '0 &&
      out_data.land_vel_z == '0)
    else $error("bad flight time result carries nonzero fields");

endmodule

`default_nettype wire

FILE: sim/tb_ballistic_arc_solver.sv
`default_nettype none

module tb_ballistic_arc_solver;
  import bas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          TAIL_CYCLES    = 40;
  localparam logic [63:0] TERM_CAP       = 64'h2000_0000_0000_0000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  ballistic_arc_solver dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // shadow of the configuration registers
  sword_t      grav   [3];
  sword_t      center [3];
  logic [31:0] half   [3];

  out_t expected_arcs[$];
  int   err_cnt;
  int   arcs_sent;
  int   arcs_checked;
  int   status_seen [4];
  int   gap_max;
  bit   rx_stall_en;
  int   rx_hold;
  int   rx_wait;
  int   idle_cycles;

  function automatic logic [63:0] shr_sat(input logic [127:0] x, input int s, inout bit sat);
    logic [127:0] r;
    r = x >> s;
    if (r > {64'd0, TERM_CAP}) begin
      sat = 1'b1;
      return TERM_CAP;
    end
    return r[63:0];
  endfunction

  // floor(num * 2^FRAC_BITS / den), clipped at cap
  function automatic logic [63:0] div_sat(input logic [127:0] num, input logic [127:0] den,
                                          input logic [63:0] cap, inout bit sat);
    logic [191:0] q;
    q = ({64'd0, num} << FRAC_BITS) / {64'd0, den};
    if (q > {128'd0, cap}) begin
      sat = 1'b1;
      return cap;
    end
    return q[63:0];
  endfunction

  function automatic sword_t clip_word(input logic signed [63:0] x, inout bit ovf);
    if (x > 64'sd2147483647) begin
      ovf = 1'b1;
      return WORD_MAX;
    end
    if (x < -64'sd2147483648) begin
      ovf = 1'b1;
      return WORD_MIN;
    end
    return sword_t'(x[31:0]);
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic out_t solve_arc(input in_t a);
    out_t                r;
    logic signed [63:0]  lw [3];
    logic signed [63:0]  aw [3];
    logic signed [63:0]  gw, d, v, p, vo_w;
    logic [63:0]         q, hg, gt, vt, g1, g2, t, tt;
    logic [127:0]        gt_w, prod, pos, neg, gsq;
    sword_t              vo [3];
    sword_t              ld [3];
    bit                  ovf, asat, junk, outside;
    r = '0;
    tt = {33'd0, a.flight_time};
    if (a.flight_time == 0) begin
      r.status = ST_BAD_TIME;
      return r;
    end
    lw[0] = a.launch_x; lw[1] = a.launch_y; lw[2] = a.launch_z;
    aw[0] = a.aim_x;    aw[1] = a.aim_y;    aw[2] = a.aim_z;
    ovf = 0; asat = 0; junk = 0; outside = 0;
    pos = '0; neg = '0; gsq = '0; t = '0;
    for (int i = 0; i < 3; i++) begin
      gw   = grav[i];
      d    = aw[i] - lw[i];
      gt_w = 128'(abs64(gw)) * 128'(tt);
      q    = div_sat(128'(abs64(d)), 128'(tt), TERM_CAP, junk);
      hg   = shr_sat(gt_w, FRAC_BITS + 1, junk);
      gt   = shr_sat(gt_w, FRAC_BITS, junk);
      v    = (d < 0 ? -$signed(q) : $signed(q)) - (gw < 0 ? -$signed(hg) : $signed(hg));
      vo[i] = clip_word(v, ovf);
      ld[i] = clip_word(v + (gw < 0 ? -$signed(gt) : $signed(gt)), ovf);
    end
    for (int i = 0; i < 3; i++) begin
      gw   = grav[i];
      vo_w = vo[i];
      prod = 128'(abs64(vo_w)) * 128'(abs64(gw));
      if ((vo_w < 0) != (gw < 0)) neg = neg + prod;
      else pos = pos + prod;
      gsq = gsq + 128'(abs64(gw)) * 128'(abs64(gw));
    end
    if (gsq != 0 && pos < neg) t = div_sat(neg - pos, gsq, tt, junk);
    for (int i = 0; i < 3; i++) begin
      gw   = grav[i];
      vo_w = vo[i];
      vt = shr_sat(128'(abs64(vo_w)) * 128'(t), FRAC_BITS, asat);
      g1 = shr_sat(128'(abs64(gw)) * 128'(t), FRAC_BITS, asat);
      g2 = shr_sat(128'(g1) * 128'(t), FRAC_BITS + 1, asat);
      p  = lw[i] + (vo_w < 0 ? -$signed(vt) : $signed(vt))
                 + (gw < 0 ? -$signed(g2) : $signed(g2));
      if (abs64(lw[i] - center[i]) > 64'(half[i]) || abs64(aw[i] - center[i]) > 64'(half[i])
          || abs64(p - center[i]) > 64'(half[i]))
        outside = 1'b1;
    end
    r.launch_vel_x = vo[0]; r.launch_vel_y = vo[1]; r.launch_vel_z = vo[2];
    r.land_vel_x   = ld[0]; r.land_vel_y   = ld[1]; r.land_vel_z   = ld[2];
    r.apex_sec     = t[TIME_BITS-1:0];
    r.status       = (ovf || asat) ? ST_OVERFLOW : (outside ? ST_OUTSIDE : ST_OK);
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_GRAVITY_X, CFG_GRAVITY_Y, CFG_GRAVITY_Z: grav[int'(idx)] = sword_t'(val[31:0]);
      CFG_BOX_CENTER_X, CFG_BOX_CENTER_Y, CFG_BOX_CENTER_Z:
        center[int'(idx) - 3] = sword_t'(val[31:0]);
      CFG_BOX_HALF_XY: begin
        half[0] = val[31:0];
        half[1] = val[63:32];
      end
      CFG_BOX_HALF_Z: half[2] = val[31:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input sword_t gx, input sword_t gy, input sword_t gz,
                            input sword_t cx, input sword_t cy, input sword_t cz,
                            input logic [31:0] hx, input logic [31:0] hy,
                            input logic [31:0] hz);
    write_reg(CFG_GRAVITY_X, 64'(gx));
    write_reg(CFG_GRAVITY_Y, {32'hFFFF_FFFF, gy});
    write_reg(CFG_GRAVITY_Z, 64'(gz));
    write_reg(CFG_BOX_CENTER_X, 64'(cx));
    write_reg(CFG_BOX_CENTER_Y, 64'(cy));
    write_reg(CFG_BOX_CENTER_Z, 64'(cz));
    write_reg(CFG_BOX_HALF_XY, {hy, hx});
    write_reg(CFG_BOX_HALF_Z, {32'hA5A5_5A5A, hz});
    cfg_we <= 1'b0;
  endtask

  // called at a rising edge; returns at the edge that takes the beat
  task automatic send_arc(input in_t arc);
    int gap;
    gap = gap_max > 0 ? $urandom_range(0, gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= arc;
    do @(posedge clk); while (!in_ready);
    expected_arcs.push_back(solve_arc(arc));
    arcs_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_arcs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic sword_t pick_coord();
    case ($urandom_range(0, 7))
      0:       return sword_t'($urandom);
      1:       return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      2:       return sword_t'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      default: return sword_t'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic time_t pick_flight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return time_t'($urandom);
      2:       return $urandom_range(0, 1) ? {TIME_BITS{1'b1}} : time_t'(1);
      default: return time_t'($urandom_range(32'h0000_4000, 32'h0008_0000));
    endcase
  endfunction

  function automatic in_t pick_arc();
    in_t a;
    a.launch_x = pick_coord(); a.launch_y = pick_coord(); a.launch_z = pick_coord();
    a.aim_x    = pick_coord(); a.aim_y    = pick_coord(); a.aim_z    = pick_coord();
    a.flight_time = pick_flight();
    return a;
  endfunction

  function automatic in_t make_arc(input sword_t lx, input sword_t ly, input sword_t lz,
                                   input sword_t ax, input sword_t ay, input sword_t az,
                                   input time_t ft);
    in_t a;
    a.launch_x = lx; a.launch_y = ly; a.launch_z = lz;
    a.aim_x = ax;    a.aim_y = ay;    a.aim_z = az;
    a.flight_time = ft;
    return a;
  endfunction

  // ------------------------------------------------------------------ tests

  task automatic test_directed();
    localparam sword_t ONE = 32'sh0001_0000;
    gap_max = 3;
    // reset gravity, zero box: everything off the origin leaves the box
    send_arc(make_arc(0, 0, 0, 0, 0, 0, 0));
    send_arc(make_arc(0, 0, 0, 0, 0, 0, time_t'(ONE)));
    send_arc(make_arc(0, 0, 0, 10 * ONE, 0, 0, time_t'(2 * ONE)));
    drain();
    set_config(0, 0, GRAV_Z_RESET, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_arc(make_arc(0, 0, 0, 20 * ONE, 5 * ONE, 0, time_t'(4 * ONE)));
    send_arc(make_arc(0, 0, 0, 10 * ONE, 0, 100 * ONE, time_t'(ONE)));
    send_arc(make_arc(0, 0, 50 * ONE, 10 * ONE, 0, -50 * ONE, time_t'(ONE)));
    send_arc(make_arc(0, 0, 0, 0, 0, 2000 * ONE, time_t'(ONE)));
    send_arc(make_arc(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX, 1));
    send_arc(make_arc(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN, 1));
    send_arc(make_arc(WORD_MAX, 0, WORD_MIN, 0, WORD_MAX, 0, {TIME_BITS{1'b1}}));
    send_arc(make_arc(ONE, -ONE, 3 * ONE, 2 * ONE, -2 * ONE, 5 * ONE, {TIME_BITS{1'b1}}));
    send_arc(make_arc(0, 0, 0, 0, 0, 0, 0));
    drain();
    set_config(0, 0, 0, 0, 0, 0, 100 << 16, 100 << 16, 100 << 16);
    send_arc(make_arc(ONE, ONE, ONE, 5 * ONE, 5 * ONE, 5 * ONE, time_t'(ONE)));
    send_arc(make_arc(ONE, ONE, ONE, 200 * ONE, 5 * ONE, 5 * ONE, time_t'(ONE)));
    drain();
    set_config(WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MIN, 0, 32'hFFFF_FFFF, 0, 1);
    send_arc(make_arc(0, 0, 0, ONE, ONE, ONE, time_t'(ONE)));
    send_arc(make_arc(0, 0, 0, 0, 0, 0, {TIME_BITS{1'b1}}));
    send_arc(make_arc(ONE, 0, 0, 0, 0, 0, 1));
    drain();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(0, 0, GRAV_Z_RESET, 0, 0, 0,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: set_config(0, 0, 0, sword_t'($urandom), sword_t'($urandom), sword_t'($urandom),
                      $urandom, $urandom, $urandom);
        2: set_config(sword_t'($urandom_range(0, 65535)) - 32'sd32768,
                      sword_t'($urandom_range(0, 65535)) - 32'sd32768,
                      -sword_t'($urandom_range(1, 32'h000A_0000)), 0, 0, 0,
                      32'h0040_0000, 32'h0040_0000, 32'h0040_0000);
        3: set_config(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MIN, 0, 0, 0);
        4: set_config(sword_t'($urandom), sword_t'($urandom), sword_t'($urandom),
                      sword_t'($urandom), sword_t'($urandom), sword_t'($urandom),
                      $urandom, $urandom, $urandom);
        default: set_config(0, 32'sh0000_8000, -32'sh0009_CCCD, 32'sh0001_0000, 0,
                            -32'sh0002_0000, 32'h0030_0000, 32'h0030_0000, 32'h0030_0000);
      endcase
      rx_stall_en = (phase != 2);
      gap_max     = (phase == 4) ? 0 : 11;
      repeat (55) send_arc(pick_arc());
      drain();
    end
    rx_stall_en = 1'b1;
  endtask

  task automatic test_backpressure();
    gap_max = 0;
    rx_hold = 300;
    repeat (70) send_arc(pick_arc());
    gap_max = 11;
    drain();
  endtask

  // ------------------------------------------------------------ checking

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_arcs.size() == 0) begin
        $error("result beat with no arc outstanding: %p", out_data);
        err_cnt++;
      end else begin
        out_t e;
        e = expected_arcs.pop_front();
        arcs_checked++;
        status_seen[int'(e.status)]++;
        if (out_data.launch_vel_x !== e.launch_vel_x) begin
          $error("launch_vel_x exp %h got %h", e.launch_vel_x, out_data.launch_vel_x);
          err_cnt++;
        end
        if (out_data.launch_vel_y !== e.launch_vel_y) begin
          $error("launch_vel_y exp %h got %h", e.launch_vel_y, out_data.launch_vel_y);
          err_cnt++;
        end
        if (out_data.launch_vel_z !== e.launch_vel_z) begin
          $error("launch_vel_z exp %h got %h", e.launch_vel_z, out_data.launch_vel_z);
          err_cnt++;
        end
        if (out_data.land_vel_x !== e.land_vel_x) begin
          $error("land_vel_x exp %h got %h", e.land_vel_x, out_data.land_vel_x);
          err_cnt++;
        end
        if (out_data.land_vel_y !== e.land_vel_y) begin
          $error("land_vel_y exp %h got %h", e.land_vel_y, out_data.land_vel_y);
          err_cnt++;
        end
        if (out_data.land_vel_z !== e.land_vel_z) begin
          $error("land_vel_z exp %h got %h", e.land_vel_z, out_data.land_vel_z);
          err_cnt++;
        end
        if (out_data.apex_sec !== e.apex_sec) begin
          $error("apex_sec exp %h got %h", e.apex_sec, out_data.apex_sec);
          err_cnt++;
        end
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status);
          err_cnt++;
        end
      end
    end
  end

  // receiver: random stall per beat, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_wait = rx_stall_en ? $urandom_range(0, 11) : 0;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_cnt = 0;
    arcs_sent = 0;
    arcs_checked = 0;
    status_seen = '{0, 0, 0, 0};
    rx_stall_en = 1'b1;
    rx_hold = 0;
    rx_wait = 0;
    idle_cycles = 0;
    gap_max = 11;
    grav = '{0, 0, GRAV_Z_RESET};
    center = '{0, 0, 0};
    half = '{0, 0, 0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_settings();
    test_backpressure();

    if (expected_arcs.size() != 0) begin
      $error("%0d results never arrived", expected_arcs.size());
      err_cnt++;
    end
    $display("%0d arcs sent, %0d results checked over 10 register settings", arcs_sent,
             arcs_checked);
    $display("status mix ok/bad time/outside/overflow: %0d/%0d/%0d/%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
